// File: hdl/i2cm_pkg.sv
// Shared types and constants for the single-byte I2C master.
`default_nettype none
package i2cm_pkg;

  localparam int unsigned ADDR_W   = 7;
  localparam int unsigned REG_W    = 16;
  localparam int unsigned IDX_W    = 2;
  localparam int unsigned IN_W     = 16;
  localparam int unsigned OUT_W    = 16;
  localparam logic [3:0]  BITS_PER_BYTE = 4'd8;

  // Register indexes on the configuration port.
  localparam logic [IDX_W-1:0] REG_DEVICE_ADDRESS   = 2'd0;
  localparam logic [IDX_W-1:0] REG_PHASE_TICKS      = 2'd1;
  localparam logic [IDX_W-1:0] REG_READ_PHASE_TICKS = 2'd2;

  localparam logic [ADDR_W-1:0] RESET_DEVICE_ADDRESS   = 7'd118;
  localparam logic [REG_W-1:0]  RESET_PHASE_TICKS      = 16'd100;
  localparam logic [REG_W-1:0]  RESET_READ_PHASE_TICKS = 16'd120;

  typedef enum logic [4:0] {
    ST_IDLE    = 5'd0,
    ST_START_A = 5'd1,
    ST_START_B = 5'd2,
    ST_START_C = 5'd3,
    ST_ABIT_HI = 5'd4,
    ST_ABIT_LO = 5'd5,
    ST_AACK_HI = 5'd6,
    ST_AACK_LO = 5'd7,
    ST_DBIT_HI = 5'd8,
    ST_DBIT_LO = 5'd9,
    ST_DACK_HI = 5'd10,
    ST_DACK_LO = 5'd11,
    ST_RBIT_H1 = 5'd12,
    ST_RBIT_H2 = 5'd13,
    ST_RBIT_LO = 5'd14,
    ST_NACK_HI = 5'd15,
    ST_NACK_LO = 5'd16,
    ST_STOP_A  = 5'd17,
    ST_STOP_B  = 5'd18,
    ST_STOP_C  = 5'd19
  } step_t;

  // One tick as classified by the front end.
  typedef struct packed {
    logic       start_cmd;
    logic       is_read;
    logic [7:0] write_byte;
    logic       sda_sample;
  } item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] device_address;
    logic [REG_W-1:0]  phase_ticks;
    logic [REG_W-1:0]  read_phase_ticks;
  } cfg_t;

endpackage
`default_nettype wire

// File: hdl/i2cm_front.sv
// Front end: accepts tick transactions, decodes them and queues them for the engine.
`default_nettype none
module i2cm_front (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        in_valid,
  output logic                       in_ready,
  input  wire  [i2cm_pkg::IN_W-1:0]  in_data,
  input  wire                        in_user,
  output logic                       q_valid,
  input  wire                        q_pop,
  output i2cm_pkg::item_t            q_item
);

  i2cm_pkg::item_t entry [2];
  i2cm_pkg::item_t decoded;
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      count;
  logic            push;

  assign in_ready = (count != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (count != 2'd0);
  assign q_item   = entry[rd_ptr];

  always_comb begin
    decoded.start_cmd  = in_data[0];
    decoded.is_read    = in_user;
    decoded.write_byte = in_data[8:1];
    decoded.sda_sample = in_data[9];
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= decoded;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop) rd_ptr <= ~rd_ptr;
      unique case ({push, q_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: hdl/i2cm_engine.sv
// Back end: bus sequencer stepped once per queued tick, with a registered result.
`default_nettype none
module i2cm_engine #(
  parameter int unsigned TIMER_WIDTH = 16
) (
  input  wire                        clk,
  input  wire                        rst,
  input  i2cm_pkg::cfg_t             cfg,
  input  wire                        q_valid,
  output logic                       q_pop,
  input  i2cm_pkg::item_t            q_item,
  output logic                       out_valid,
  input  wire                        out_ready,
  output logic [i2cm_pkg::OUT_W-1:0] out_data
);

  localparam int unsigned EXT_W = (TIMER_WIDTH > i2cm_pkg::REG_W) ? TIMER_WIDTH
                                                                    : i2cm_pkg::REG_W;

  i2cm_pkg::step_t        step, step_next, cur;
  logic [TIMER_WIDTH-1:0] tick, tick_next, tick_cur;
  logic [3:0]             bitc, bitc_next, bit_inc;
  logic [7:0]             shreg, shreg_next;
  logic [7:0]             rhold, rhold_next;
  logic [7:0]             pdata, pdata_next;
  logic                   pread, pread_next;
  logic [1:0]             ack, ack_next;

  logic [EXT_W-1:0]       plen_ext, rlen_ext;
  logic [TIMER_WIDTH-1:0] plen, rlen, len;
  logic [TIMER_WIDTH:0]   tick_inc;
  logic                   scl, sda, drv, done;
  logic [i2cm_pkg::OUT_W-1:0] result;

  assign plen_ext = EXT_W'(cfg.phase_ticks);
  assign rlen_ext = EXT_W'(cfg.read_phase_ticks);

  // A zero length behaves as one tick.
  always_comb begin
    plen = plen_ext[TIMER_WIDTH-1:0];
    rlen = rlen_ext[TIMER_WIDTH-1:0];
    if (plen == '0) plen = TIMER_WIDTH'(1);
    if (rlen == '0) rlen = TIMER_WIDTH'(1);
  end

  assign q_pop = q_valid && (!out_valid || out_ready);

  always_comb begin
    cur        = step;
    tick_cur   = tick;
    bitc_next  = bitc;
    shreg_next = shreg;
    rhold_next = rhold;
    pdata_next = pdata;
    pread_next = pread;
    ack_next   = ack;
    tick_next  = tick;
    step_next  = step;
    bit_inc    = bitc + 4'd1;
    scl        = 1'b1;
    sda        = 1'b1;
    drv        = 1'b0;
    done       = 1'b0;
    len        = plen;
    tick_inc   = '0;

    if (step == i2cm_pkg::ST_IDLE && q_item.start_cmd) begin
      pread_next = q_item.is_read;
      pdata_next = q_item.write_byte;
      shreg_next = {cfg.device_address, q_item.is_read};
      ack_next   = 2'b00;
      bitc_next  = 4'd0;
      bit_inc    = 4'd1;
      tick_cur   = '0;
      cur        = i2cm_pkg::ST_START_A;
    end

    if (cur != i2cm_pkg::ST_IDLE) begin
      len = (cur == i2cm_pkg::ST_RBIT_H1 || cur == i2cm_pkg::ST_RBIT_H2) ? rlen : plen;

      // Sample acknowledge in the middle of the SCL high phase.
      if (tick_cur == (plen >> 1)) begin
        if (cur == i2cm_pkg::ST_AACK_HI) ack_next[0] = ~q_item.sda_sample;
        if (cur == i2cm_pkg::ST_DACK_HI) ack_next[1] = ~q_item.sda_sample;
      end
      if (cur == i2cm_pkg::ST_RBIT_H2 && tick_cur == '0) begin
        shreg_next = {shreg_next[6:0], q_item.sda_sample};
      end

      unique case (cur)
        i2cm_pkg::ST_START_A: begin scl = 1'b1; sda = 1'b1; drv = 1'b1; end
        i2cm_pkg::ST_START_B: begin scl = 1'b1; sda = 1'b0; drv = 1'b1; end
        i2cm_pkg::ST_START_C: begin scl = 1'b0; sda = 1'b0; drv = 1'b1; end
        i2cm_pkg::ST_ABIT_HI,
        i2cm_pkg::ST_DBIT_HI: begin scl = 1'b1; sda = shreg_next[7]; drv = 1'b1; end
        i2cm_pkg::ST_ABIT_LO,
        i2cm_pkg::ST_DBIT_LO: begin scl = 1'b0; sda = shreg_next[7]; drv = 1'b1; end
        i2cm_pkg::ST_AACK_HI, i2cm_pkg::ST_DACK_HI, i2cm_pkg::ST_NACK_HI,
        i2cm_pkg::ST_RBIT_H1, i2cm_pkg::ST_RBIT_H2: begin
          scl = 1'b1; sda = 1'b1; drv = 1'b0;
        end
        i2cm_pkg::ST_AACK_LO, i2cm_pkg::ST_DACK_LO, i2cm_pkg::ST_NACK_LO,
        i2cm_pkg::ST_RBIT_LO: begin scl = 1'b0; sda = 1'b1; drv = 1'b0; end
        i2cm_pkg::ST_STOP_A: begin scl = 1'b0; sda = 1'b0; drv = 1'b1; end
        i2cm_pkg::ST_STOP_B: begin scl = 1'b1; sda = 1'b0; drv = 1'b1; end
        i2cm_pkg::ST_STOP_C: begin scl = 1'b1; sda = 1'b1; drv = 1'b1; end
        default:             begin scl = 1'b1; sda = 1'b1; drv = 1'b0; end
      endcase

      tick_inc  = {1'b0, tick_cur} + (TIMER_WIDTH+1)'(1);
      tick_next = tick_inc[TIMER_WIDTH-1:0];
      step_next = cur;
      if (tick_inc >= {1'b0, len}) begin
        tick_next = '0;
        unique case (cur)
          i2cm_pkg::ST_START_A: step_next = i2cm_pkg::ST_START_B;
          i2cm_pkg::ST_START_B: step_next = i2cm_pkg::ST_START_C;
          i2cm_pkg::ST_START_C: step_next = i2cm_pkg::ST_ABIT_HI;
          i2cm_pkg::ST_ABIT_HI: step_next = i2cm_pkg::ST_ABIT_LO;
          i2cm_pkg::ST_DBIT_HI: step_next = i2cm_pkg::ST_DBIT_LO;
          i2cm_pkg::ST_ABIT_LO, i2cm_pkg::ST_DBIT_LO: begin
            shreg_next = {shreg_next[6:0], 1'b0};
            bitc_next  = bit_inc;
            if (bit_inc >= i2cm_pkg::BITS_PER_BYTE) begin
              bitc_next = 4'd0;
              step_next = (cur == i2cm_pkg::ST_ABIT_LO) ? i2cm_pkg::ST_AACK_HI
                                                        : i2cm_pkg::ST_DACK_HI;
            end else begin
              step_next = (cur == i2cm_pkg::ST_ABIT_LO) ? i2cm_pkg::ST_ABIT_HI
                                                        : i2cm_pkg::ST_DBIT_HI;
            end
          end
          i2cm_pkg::ST_AACK_HI: step_next = i2cm_pkg::ST_AACK_LO;
          i2cm_pkg::ST_AACK_LO: begin
            if (pread_next) begin
              shreg_next = 8'd0;
              step_next  = i2cm_pkg::ST_RBIT_H1;
            end else begin
              shreg_next = pdata_next;
              step_next  = i2cm_pkg::ST_DBIT_HI;
            end
          end
          i2cm_pkg::ST_DACK_HI: step_next = i2cm_pkg::ST_DACK_LO;
          i2cm_pkg::ST_DACK_LO: step_next = i2cm_pkg::ST_STOP_A;
          i2cm_pkg::ST_RBIT_H1: step_next = i2cm_pkg::ST_RBIT_H2;
          i2cm_pkg::ST_RBIT_H2: step_next = i2cm_pkg::ST_RBIT_LO;
          i2cm_pkg::ST_RBIT_LO: begin
            bitc_next = bit_inc;
            if (bit_inc >= i2cm_pkg::BITS_PER_BYTE) begin
              bitc_next  = 4'd0;
              rhold_next = shreg_next;
              step_next  = i2cm_pkg::ST_NACK_HI;
            end else begin
              step_next  = i2cm_pkg::ST_RBIT_H1;
            end
          end
          i2cm_pkg::ST_NACK_HI: step_next = i2cm_pkg::ST_NACK_LO;
          i2cm_pkg::ST_NACK_LO: step_next = i2cm_pkg::ST_STOP_A;
          i2cm_pkg::ST_STOP_A:  step_next = i2cm_pkg::ST_STOP_B;
          i2cm_pkg::ST_STOP_B:  step_next = i2cm_pkg::ST_STOP_C;
          default: begin
            step_next = i2cm_pkg::ST_IDLE;
            done      = 1'b1;
          end
        endcase
      end
    end

    result = {1'b0, ack_next[1], ack_next[0], rhold_next, done,
              (step_next != i2cm_pkg::ST_IDLE), drv, sda, scl};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= i2cm_pkg::ST_IDLE;
      tick      <= '0;
      bitc      <= 4'd0;
      shreg     <= 8'd0;
      rhold     <= 8'd0;
      pdata     <= 8'd0;
      pread     <= 1'b0;
      ack       <= 2'b00;
      out_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        step  <= step_next;
        tick  <= tick_next;
        bitc  <= bitc_next;
        shreg <= shreg_next;
        rhold <= rhold_next;
        pdata <= pdata_next;
        pread <= pread_next;
        ack   <= ack_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) out_data <= result;
  end

endmodule
`default_nettype wire

// File: hdl/i2c_single_byte_master_top.sv
// Top level of the single-byte I2C master: configuration registers, front end and engine.
// A tick is queued, then registered in the engine's output register for the master side.
// Throughput: one tick per cycle unless m_tready stalls; the engine steps once per tick.
// A two-entry queue separates the front end from the engine and its output register.
// Reset (synchronous, rst high): queue empty, sequencer idle with SCL high and SDA
// released, flags and read byte cleared, registers at address 118, phase 100, read 120.
`default_nettype none
module i2c_single_byte_master_top #(
  parameter int unsigned TIMER_WIDTH = 16
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          s_tvalid,
  output logic                         s_tready,
  // s_tdata: [0] cmd_valid, [8:1] write_byte, [9] sda_sample, [15:10] zero
  input  wire  [i2cm_pkg::IN_W-1:0]    s_tdata,
  // s_tuser: [0] opcode
  input  wire                          s_tuser,
  output logic                         m_tvalid,
  input  wire                          m_tready,
  // m_tdata: [0] scl_level, [1] sda_level, [2] sda_driven, [3] busy_res,
  // [4] done_res, [12:5] read_byte, [13] address_acked, [14] data_acked, [15] zero
  output logic [i2cm_pkg::OUT_W-1:0]   m_tdata,
  input  wire                          cfg_we,
  input  wire  [i2cm_pkg::IDX_W-1:0]   cfg_index,
  input  wire  [i2cm_pkg::REG_W-1:0]   cfg_data
);

  i2cm_pkg::cfg_t  cfg;
  i2cm_pkg::item_t q_item;
  logic            q_valid;
  logic            q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.device_address   <= i2cm_pkg::RESET_DEVICE_ADDRESS;
      cfg.phase_ticks      <= i2cm_pkg::RESET_PHASE_TICKS;
      cfg.read_phase_ticks <= i2cm_pkg::RESET_READ_PHASE_TICKS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        i2cm_pkg::REG_DEVICE_ADDRESS:
          cfg.device_address <= cfg_data[i2cm_pkg::ADDR_W-1:0];
        i2cm_pkg::REG_PHASE_TICKS:      cfg.phase_ticks      <= cfg_data;
        i2cm_pkg::REG_READ_PHASE_TICKS: cfg.read_phase_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  i2cm_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_data  (s_tdata),
    .in_user  (s_tuser),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_item   (q_item)
  );

  i2cm_engine #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_item    (q_item),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata)
  );

  // A stop completion always leaves the bus idle.
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[4] |-> !m_tdata[3])
    else $error("done_res asserted while busy_res high");

  // A released data line reads at the pull-up level.
  a_released_high: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[2] |-> m_tdata[1])
    else $error("sda_level low while SDA released");

  // Done pulses for a single tick only.
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && m_tdata[4] |=> !(m_tvalid && m_tdata[4]))
    else $error("done_res on two consecutive results");

  // A full queue always has an item for the engine.
  a_full_has_item: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> q_valid)
    else $error("input stalled with an empty queue");

endmodule
`default_nettype wire

// File: tb/testbench.sv
// Self-checking stream testbench for the single-byte I2C master tick engine.
`default_nettype none
module testbench;

  localparam logic [i2cm_pkg::IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int STALL_LIMIT   = 3000;
  localparam int SETTLE_CYCLES = 6;
  localparam int HOLD_CYCLES   = 400;

  // One result word, laid out as on m_tdata from the highest bit down.
  typedef struct packed {
    logic       pad;
    logic       data_acked;
    logic       addr_acked;
    logic [7:0] rd_byte;
    logic       done;
    logic       busy;
    logic       sda_drv;
    logic       sda_lvl;
    logic       scl;
  } bus_result_t;

  // One directed tick; fixed is used in place of the predicted word when typed is set.
  typedef struct packed {
    logic        cmd;
    logic        op;
    logic [7:0]  wbyte;
    logic        sda;
    logic        typed;
    logic [15:0] fixed;
  } tick_row_t;

  logic clk;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [i2cm_pkg::IN_W-1:0] s_tdata = '0;
  logic s_tuser = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [i2cm_pkg::OUT_W-1:0] m_tdata;
  logic cfg_we = 1'b0;
  logic [i2cm_pkg::IDX_W-1:0] cfg_index = '0;
  logic [i2cm_pkg::REG_W-1:0] cfg_data = '0;

  i2c_single_byte_master_top #(.TIMER_WIDTH(16)) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Predictor copy of the registers and the sequencer.
  logic [i2cm_pkg::ADDR_W-1:0] dev_addr = i2cm_pkg::RESET_DEVICE_ADDRESS;
  logic [i2cm_pkg::REG_W-1:0]  ph_ticks = i2cm_pkg::RESET_PHASE_TICKS;
  logic [i2cm_pkg::REG_W-1:0]  rd_ticks = i2cm_pkg::RESET_READ_PHASE_TICKS;
  i2cm_pkg::step_t seq = i2cm_pkg::ST_IDLE;
  int unsigned tick_cnt = 0;
  logic [3:0]  bit_cnt = '0;
  logic [7:0]  shreg = '0;
  logic [7:0]  rd_hold = '0;
  logic [7:0]  pend_data = '0;
  logic        pend_rd = 1'b0;
  logic [1:0]  acks = '0;
  logic        scl = 1'b1;
  logic        sda_lvl = 1'b1;
  logic        sda_drv = 1'b0;

  bus_result_t expected_results[$];
  int fail_count = 0;
  int stall_cycles = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int rx_hold_req = 0;
  int hold_left = 0;

  tick_row_t directed_rows [24] = '{
    {1'b0, 1'b1, 8'hFF, 1'b1, 1'b1, 16'h0003},  // idle, fields ignored
    {1'b1, 1'b0, 8'h00, 1'b1, 1'b1, 16'h000F},  // write accepted, start high/high
    {1'b1, 1'b1, 8'hFF, 1'b0, 1'b1, 16'h000D},  // command while busy, start sda low
    {1'b0, 1'b0, 8'h00, 1'b0, 1'b1, 16'h000C},  // start both low
    {1'b0, 1'b0, 8'h00, 1'b1, 1'b1, 16'h000F},  // first address bit high phase
    {1'b0, 1'b0, 8'h00, 1'b1, 1'b1, 16'h000E},
    {1'b1, 1'b0, 8'h55, 1'b0, 1'b0, 16'h0000},
    {1'b0, 1'b1, 8'hAA, 1'b1, 1'b0, 16'h0000},
    {1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 16'h0000},
    {1'b0, 1'b0, 8'h00, 1'b1, 1'b0, 16'h0000},
    {1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 16'h0000},
    {1'b0, 1'b0, 8'h00, 1'b1, 1'b0, 16'h0000},
    {1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 16'h0000},
    {1'b0, 1'b0, 8'h00, 1'b1, 1'b0, 16'h0000},
    {1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 16'h0000},
    {1'b0, 1'b0, 8'h00, 1'b1, 1'b0, 16'h0000},
    {1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 16'h0000},
    {1'b0, 1'b0, 8'h00, 1'b1, 1'b0, 16'h0000},
    {1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 16'h0000},
    {1'b0, 1'b0, 8'h00, 1'b1, 1'b0, 16'h0000},
    {1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 16'h0000},  // address ack clock, target acks
    {1'b0, 1'b0, 8'h00, 1'b1, 1'b0, 16'h0000},
    {1'b1, 1'b1, 8'hFF, 1'b1, 1'b0, 16'h0000},
    {1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 16'h0000}
  };

  function automatic int unsigned span(input logic [i2cm_pkg::REG_W-1:0] r);
    return (r == '0) ? 1 : int'(r);
  endfunction

  function automatic void drive_pins(input i2cm_pkg::step_t s);
    scl = 1'b1;
    sda_lvl = 1'b1;
    sda_drv = 1'b0;
    case (s)
      i2cm_pkg::ST_START_A, i2cm_pkg::ST_STOP_C: begin
        sda_drv = 1'b1;
      end
      i2cm_pkg::ST_START_B, i2cm_pkg::ST_STOP_B: begin
        sda_lvl = 1'b0;
        sda_drv = 1'b1;
      end
      i2cm_pkg::ST_START_C, i2cm_pkg::ST_STOP_A: begin
        scl = 1'b0;
        sda_lvl = 1'b0;
        sda_drv = 1'b1;
      end
      i2cm_pkg::ST_ABIT_HI, i2cm_pkg::ST_DBIT_HI: begin
        sda_lvl = shreg[7];
        sda_drv = 1'b1;
      end
      i2cm_pkg::ST_ABIT_LO, i2cm_pkg::ST_DBIT_LO: begin
        scl = 1'b0;
        sda_lvl = shreg[7];
        sda_drv = 1'b1;
      end
      i2cm_pkg::ST_AACK_LO, i2cm_pkg::ST_DACK_LO, i2cm_pkg::ST_NACK_LO,
      i2cm_pkg::ST_RBIT_LO: begin
        scl = 1'b0;
      end
      default: begin
      end
    endcase
  endfunction

  // Leave step s and return the step that follows it.
  function automatic i2cm_pkg::step_t next_step(input i2cm_pkg::step_t s);
    case (s)
      i2cm_pkg::ST_START_A: return i2cm_pkg::ST_START_B;
      i2cm_pkg::ST_START_B: return i2cm_pkg::ST_START_C;
      i2cm_pkg::ST_START_C: return i2cm_pkg::ST_ABIT_HI;
      i2cm_pkg::ST_ABIT_HI: return i2cm_pkg::ST_ABIT_LO;
      i2cm_pkg::ST_DBIT_HI: return i2cm_pkg::ST_DBIT_LO;
      i2cm_pkg::ST_ABIT_LO, i2cm_pkg::ST_DBIT_LO: begin
        shreg = {shreg[6:0], 1'b0};
        bit_cnt = bit_cnt + 4'd1;
        if (bit_cnt >= i2cm_pkg::BITS_PER_BYTE) begin
          bit_cnt = '0;
          return (s == i2cm_pkg::ST_ABIT_LO) ? i2cm_pkg::ST_AACK_HI : i2cm_pkg::ST_DACK_HI;
        end
        return (s == i2cm_pkg::ST_ABIT_LO) ? i2cm_pkg::ST_ABIT_HI : i2cm_pkg::ST_DBIT_HI;
      end
      i2cm_pkg::ST_AACK_HI: return i2cm_pkg::ST_AACK_LO;
      i2cm_pkg::ST_AACK_LO: begin
        if (pend_rd) begin
          shreg = '0;
          return i2cm_pkg::ST_RBIT_H1;
        end
        shreg = pend_data;
        return i2cm_pkg::ST_DBIT_HI;
      end
      i2cm_pkg::ST_DACK_HI: return i2cm_pkg::ST_DACK_LO;
      i2cm_pkg::ST_DACK_LO: return i2cm_pkg::ST_STOP_A;
      i2cm_pkg::ST_RBIT_H1: return i2cm_pkg::ST_RBIT_H2;
      i2cm_pkg::ST_RBIT_H2: return i2cm_pkg::ST_RBIT_LO;
      i2cm_pkg::ST_RBIT_LO: begin
        bit_cnt = bit_cnt + 4'd1;
        if (bit_cnt >= i2cm_pkg::BITS_PER_BYTE) begin
          bit_cnt = '0;
          rd_hold = shreg;
          return i2cm_pkg::ST_NACK_HI;
        end
        return i2cm_pkg::ST_RBIT_H1;
      end
      i2cm_pkg::ST_NACK_HI: return i2cm_pkg::ST_NACK_LO;
      i2cm_pkg::ST_NACK_LO: return i2cm_pkg::ST_STOP_A;
      i2cm_pkg::ST_STOP_A: return i2cm_pkg::ST_STOP_B;
      i2cm_pkg::ST_STOP_B: return i2cm_pkg::ST_STOP_C;
      default: return i2cm_pkg::ST_IDLE;
    endcase
  endfunction

  // Step the bus engine by one tick and return the pin and status word it shows.
  function automatic bus_result_t bus_tick(input logic cmd, input logic op,
                                           input logic [7:0] wbyte, input logic sda);
    bus_result_t r;
    int unsigned len;
    i2cm_pkg::step_t s;
    logic done;
    done = 1'b0;
    if (seq == i2cm_pkg::ST_IDLE) begin
      drive_pins(i2cm_pkg::ST_IDLE);
      if (cmd) begin
        pend_rd = op;
        pend_data = wbyte;
        shreg = {dev_addr, op};
        acks = '0;
        bit_cnt = '0;
        tick_cnt = 0;
        seq = i2cm_pkg::ST_START_A;
      end
    end
    if (seq != i2cm_pkg::ST_IDLE) begin
      s = seq;
      len = (s == i2cm_pkg::ST_RBIT_H1 || s == i2cm_pkg::ST_RBIT_H2) ? span(rd_ticks)
                                                                     : span(ph_ticks);
      if (tick_cnt == (span(ph_ticks) >> 1)) begin
        if (s == i2cm_pkg::ST_AACK_HI) acks[0] = ~sda;
        else if (s == i2cm_pkg::ST_DACK_HI) acks[1] = ~sda;
      end
      if (s == i2cm_pkg::ST_RBIT_H2 && tick_cnt == 0) shreg = {shreg[6:0], sda};
      drive_pins(s);
      tick_cnt++;
      if (tick_cnt >= len) begin
        tick_cnt = 0;
        seq = next_step(s);
        done = (seq == i2cm_pkg::ST_IDLE);
      end
    end
    r.pad = 1'b0;
    r.data_acked = acks[1];
    r.addr_acked = acks[0];
    r.rd_byte = rd_hold;
    r.done = done;
    r.busy = (seq != i2cm_pkg::ST_IDLE);
    r.sda_drv = sda_drv;
    r.sda_lvl = sda_lvl;
    r.scl = scl;
    return r;
  endfunction

  task automatic write_reg(input logic [i2cm_pkg::IDX_W-1:0] idx,
                           input logic [i2cm_pkg::REG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      i2cm_pkg::REG_DEVICE_ADDRESS:   dev_addr = val[i2cm_pkg::ADDR_W-1:0];
      i2cm_pkg::REG_PHASE_TICKS:      ph_ticks = val;
      i2cm_pkg::REG_READ_PHASE_TICKS: rd_ticks = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Offer one tick and hold it until the transaction completes.
  task automatic send_tick(input logic cmd, input logic op, input logic [7:0] wbyte,
                           input logic sda);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {6'b0, sda, wbyte, cmd};
    s_tuser <= op;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic drain;
    s_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input logic [i2cm_pkg::ADDR_W-1:0] addr,
                           input logic [i2cm_pkg::REG_W-1:0] ph,
                           input logic [i2cm_pkg::REG_W-1:0] rd, input int n, input int txp,
                           input int rxp, input int hold);
    logic cmd, op, sda;
    logic [7:0] wbyte;
    drain();
    write_reg(i2cm_pkg::REG_DEVICE_ADDRESS, i2cm_pkg::REG_W'(addr));
    write_reg(i2cm_pkg::REG_PHASE_TICKS, ph);
    write_reg(i2cm_pkg::REG_READ_PHASE_TICKS, rd);
    tx_idle_pct = txp;
    rx_idle_pct = rxp;
    rx_hold_req = hold;
    for (int i = 0; i < n; i++) begin
      cmd = ($urandom_range(0, 3) == 0);
      op = 1'($urandom_range(0, 1));
      wbyte = 8'($urandom_range(0, 255));
      sda = 1'($urandom_range(0, 1));
      send_tick(cmd, op, wbyte, sda);
      expected_results.push_back(bus_tick(cmd, op, wbyte, sda));
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
  end

  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("Test completed with failures");
    $finish;
  end

  // Receiver: random backpressure plus an occasional long hold-off.
  always @(posedge clk) begin
    if (rx_hold_req != 0) begin
      hold_left = rx_hold_req;
      rx_hold_req = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    bus_result_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata;
      if (expected_results.size() == 0) begin
        if (fail_count < 10) $display("unexpected result %h with nothing pending", got);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        if (got.scl !== want.scl || got.sda_lvl !== want.sda_lvl ||
            got.sda_drv !== want.sda_drv || got.busy !== want.busy ||
            got.done !== want.done || got.rd_byte !== want.rd_byte ||
            got.addr_acked !== want.addr_acked || got.data_acked !== want.data_acked ||
            got.pad !== want.pad) begin
          // Fields: scl, sda, drv, busy, done, read byte, address ack, data ack.
          if (fail_count < 10)
            $display("mismatch exp %b%b%b%b%b %h %b%b got %b%b%b%b%b %h %b%b",
                     want.scl, want.sda_lvl, want.sda_drv, want.busy, want.done,
                     want.rd_byte, want.addr_acked, want.data_acked,
                     got.scl, got.sda_lvl, got.sda_drv, got.busy, got.done,
                     got.rd_byte, got.addr_acked, got.data_acked);
          fail_count++;
        end
      end
    end
  end

  initial begin
    tick_row_t row;
    bus_result_t predicted;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Short phases, reset address: walk a write through start and address.
    write_reg(i2cm_pkg::REG_PHASE_TICKS, 16'd1);
    write_reg(i2cm_pkg::REG_READ_PHASE_TICKS, 16'd1);
    tx_idle_pct = 37;
    rx_idle_pct = 49;
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      send_tick(row.cmd, row.op, row.wbyte, row.sda);
      predicted = bus_tick(row.cmd, row.op, row.wbyte, row.sda);
      expected_results.push_back(row.typed ? bus_result_t'(row.fixed) : predicted);
    end

    run_phase(7'd0,   16'd1, 16'd1, 250, 37, 49, HOLD_CYCLES);
    run_phase(7'd127, 16'd0, 16'd0, 250, 37, 49, 0);
    run_phase(i2cm_pkg::ADDR_W'($urandom_range(1, 126)), 16'd2, 16'd3, 300, 49, 37, 0);
    run_phase(i2cm_pkg::ADDR_W'($urandom_range(1, 126)), 16'd3, 16'd2, 300, 49, 37, 0);
    drain();
    write_reg(REG_UNUSED, i2cm_pkg::REG_W'($urandom_range(0, 65535)));
    run_phase(i2cm_pkg::ADDR_W'($urandom_range(1, 126)), 16'hFFFF, 16'hFFFF, 100, 0, 0, 0);
    run_phase(i2cm_pkg::ADDR_W'($urandom_range(1, 126)), 16'd1, 16'd4, 300, 0, 0,
              HOLD_CYCLES);

    drain();
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
`default_nettype wire
